FILE: rtl/cot_pkg.sv
//------------------------------------------------------------------------------
// cot_pkg
// Shared widths, payload types and codes for the capsule overlap test core.
//------------------------------------------------------------------------------
`default_nettype none

package cot_pkg;

    localparam int COORD_BITS = 16;

    // difference of two coordinates
    localparam int DW = COORD_BITS + 1;
    // signed product of two differences
    localparam int PW = 2 * DW;
    // signed sum of two products (dot, cross)
    localparam int SW = PW + 1;
    // unsigned squared magnitudes: |cross|, len^2, dist^2, rsum^2
    localparam int UW = 2 * COORD_BITS + 2;
    // radius sum
    localparam int RW = COORD_BITS + 1;
    // half of a UW word for split multiplies
    localparam int HW = UW / 2;
    // full square of a UW word
    localparam int QW = 4 * HW;

    localparam int LANES = 4;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_CROSS  = 2'd1,
        KIND_RADIUS = 2'd2
    } kind_t;

    // where the point projects onto the segment
    typedef enum logic [1:0] {
        MODE_SIDE  = 2'd0,
        MODE_START = 2'd1,
        MODE_END   = 2'd2
    } mode_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_start_x;
        logic signed [COORD_BITS-1:0] a_start_y;
        logic signed [COORD_BITS-1:0] a_end_x;
        logic signed [COORD_BITS-1:0] a_end_y;
        logic        [COORD_BITS-1:0] a_radius;
        logic signed [COORD_BITS-1:0] b_start_x;
        logic signed [COORD_BITS-1:0] b_start_y;
        logic signed [COORD_BITS-1:0] b_end_x;
        logic signed [COORD_BITS-1:0] b_end_y;
        logic        [COORD_BITS-1:0] b_radius;
    } pair_t;

    typedef struct packed {
        logic  touching;
        kind_t contact_kind;
    } result_t;

    typedef struct packed {
        mode_t         mode;
        logic [UW-1:0] cr_abs;
        logic [UW-1:0] len2;
        logic [UW-1:0] dist2;
    } lane_t;

    typedef struct packed {
        logic                 a_zero;
        logic                 b_zero;
        logic                 cross_hit;
        logic [UW-1:0]        rsq;
        lane_t [LANES-1:0]    lane;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

FILE: rtl/capsule_overlap_test_core.sv
//------------------------------------------------------------------------------
// capsule_overlap_test_core
// Contact test between two 2D capsules (segment plus radius), one pair per item.
//------------------------------------------------------------------------------
// Usage:
//   pair channel   : pair_valid / pair_stall / pair, both capsules in one item.
//   result channel : result_valid / result_stall / result, touching and kind.
//   An item moves at a rising edge where valid is high and stall is low.
//   Path: a pair passes three front stages, the queue, one compare stage and
//   the output register. Front and back are fully pipelined, so throughput
//   is one pair per cycle while result_stall is low.
//   The front and back are parted by a 2-entry queue; when result_stall holds,
//   the back freezes, the queue fills, then the front fills, and pair_stall
//   rises once about seven items are in flight. pair_stall depends only on
//   registered state, never combinationally on result_stall.
//   Reset (rst_n low, asynchronous) empties all stages and the queue; there is
//   no configuration and no stored state across items.
//------------------------------------------------------------------------------
`default_nettype none

module capsule_overlap_test_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pair_valid,
    output logic                   pair_stall,
    input  wire cot_pkg::pair_t    pair,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output cot_pkg::result_t       result
);
    import cot_pkg::*;

    q_stat_t stat;
    logic    push, pop;
    entry_t  push_data, pop_data;

    // front: differences, products, sums, endpoint classification
    cot_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_stall (pair_stall),
        .pair       (pair),
        .stat       (stat),
        .push       (push),
        .push_data  (push_data)
    );

    // decoupling queue
    cot_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (stat)
    );

    // back: wide squared compares and result selection
    cot_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .stat         (stat),
        .pop_data     (pop_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // no write into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) stat.full |-> !push)
        else $error("queue push while full");

    // no read from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) stat.empty |-> !pop)
        else $error("queue pop while empty");

    // touching flag agrees with the kind code
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.touching == (result.contact_kind != KIND_NONE)))
        else $error("touching and contact_kind disagree");

    // queue can never be full and empty at once
    assert property (@(posedge clk) disable iff (!rst_n) !(stat.full && stat.empty))
        else $error("queue status inconsistent");

endmodule

`default_nettype wire

FILE: rtl/cot_front.sv
//------------------------------------------------------------------------------
// cot_front
// Accepts pairs, forms dot/cross/distance terms and classifies each endpoint.
//------------------------------------------------------------------------------
`default_nettype none

module cot_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pair_valid,
    output logic                  pair_stall,
    input  wire cot_pkg::pair_t   pair,
    input  wire cot_pkg::q_stat_t stat,
    output logic                  push,
    output cot_pkg::entry_t       push_data
);
    import cot_pkg::*;

    function automatic logic signed [DW-1:0] sdiff(
        input logic signed [COORD_BITS-1:0] p,
        input logic signed [COORD_BITS-1:0] q
    );
        logic signed [DW-1:0] pe;
        logic signed [DW-1:0] qe;
        pe = {p[COORD_BITS-1], p};
        qe = {q[COORD_BITS-1], q};
        return pe - qe;
    endfunction

    logic f1_v_reg, f2_v_reg, f3_v_reg;
    logic f1_rdy, f2_rdy, f3_rdy;

    // stage 1: differences
    logic signed [DW-1:0] adx_reg, ady_reg, bdx_reg, bdy_reg;
    logic signed [DW-1:0] vx_reg [LANES];
    logic signed [DW-1:0] vy_reg [LANES];
    logic signed [DW-1:0] wx_reg [LANES];
    logic signed [DW-1:0] wy_reg [LANES];
    logic [RW-1:0]        rsum_reg;
    logic                 az1_reg, bz1_reg;

    // stage 2: products
    logic signed [PW-1:0] hx_reg [LANES];
    logic signed [PW-1:0] hy_reg [LANES];
    logic signed [PW-1:0] c1_reg [LANES];
    logic signed [PW-1:0] c2_reg [LANES];
    logic signed [PW-1:0] vvx_reg [LANES];
    logic signed [PW-1:0] vvy_reg [LANES];
    logic signed [PW-1:0] wwx_reg [LANES];
    logic signed [PW-1:0] wwy_reg [LANES];
    logic signed [PW-1:0] axx_reg, ayy_reg, bxx_reg, byy_reg;
    logic [UW-1:0]        rsq2_reg;
    logic                 az2_reg, bz2_reg;

    // stage 3: sums
    logic signed [SW-1:0] h_reg  [LANES];
    logic signed [SW-1:0] cr_reg [LANES];
    logic [UW-1:0]        dv_reg [LANES];
    logic [UW-1:0]        dw_reg [LANES];
    logic [UW-1:0]        la_reg, lb_reg, rsq3_reg;
    logic                 az3_reg, bz3_reg;

    logic signed [DW-1:0] ldx [LANES];
    logic signed [DW-1:0] ldy [LANES];

    always_comb
    begin
        f3_rdy     = !f3_v_reg || !stat.full;
        f2_rdy     = !f2_v_reg || f3_rdy;
        f1_rdy     = !f1_v_reg || f2_rdy;
        pair_stall = !f1_rdy;
        push       = f3_v_reg && !stat.full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end
        else
        begin
            if (f1_rdy)
                f1_v_reg <= pair_valid;
            if (f2_rdy)
                f2_v_reg <= f1_v_reg;
            if (f3_rdy)
                f3_v_reg <= f2_v_reg;
        end
    end

    // lanes 0,1: points of b against capsule a; lanes 2,3: points of a against b
    always_ff @(posedge clk)
    begin
        if (f1_rdy)
        begin
            adx_reg  <= sdiff(pair.a_end_x, pair.a_start_x);
            ady_reg  <= sdiff(pair.a_end_y, pair.a_start_y);
            bdx_reg  <= sdiff(pair.b_end_x, pair.b_start_x);
            bdy_reg  <= sdiff(pair.b_end_y, pair.b_start_y);
            vx_reg[0] <= sdiff(pair.b_start_x, pair.a_start_x);
            vy_reg[0] <= sdiff(pair.b_start_y, pair.a_start_y);
            vx_reg[1] <= sdiff(pair.b_end_x, pair.a_start_x);
            vy_reg[1] <= sdiff(pair.b_end_y, pair.a_start_y);
            vx_reg[2] <= sdiff(pair.a_start_x, pair.b_start_x);
            vy_reg[2] <= sdiff(pair.a_start_y, pair.b_start_y);
            vx_reg[3] <= sdiff(pair.a_end_x, pair.b_start_x);
            vy_reg[3] <= sdiff(pair.a_end_y, pair.b_start_y);
            wx_reg[0] <= sdiff(pair.b_start_x, pair.a_end_x);
            wy_reg[0] <= sdiff(pair.b_start_y, pair.a_end_y);
            wx_reg[1] <= sdiff(pair.b_end_x, pair.a_end_x);
            wy_reg[1] <= sdiff(pair.b_end_y, pair.a_end_y);
            wx_reg[2] <= sdiff(pair.a_start_x, pair.b_end_x);
            wy_reg[2] <= sdiff(pair.a_start_y, pair.b_end_y);
            wx_reg[3] <= sdiff(pair.a_end_x, pair.b_end_x);
            wy_reg[3] <= sdiff(pair.a_end_y, pair.b_end_y);
            rsum_reg <= {1'b0, pair.a_radius} + {1'b0, pair.b_radius};
            az1_reg  <= (pair.a_start_x == pair.a_end_x) && (pair.a_start_y == pair.a_end_y);
            bz1_reg  <= (pair.b_start_x == pair.b_end_x) && (pair.b_start_y == pair.b_end_y);
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            ldx[i] = (i < 2) ? adx_reg : bdx_reg;
            ldy[i] = (i < 2) ? ady_reg : bdy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f2_rdy)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                hx_reg[i]  <= ldx[i] * vx_reg[i];
                hy_reg[i]  <= ldy[i] * vy_reg[i];
                c1_reg[i]  <= ldx[i] * vy_reg[i];
                c2_reg[i]  <= ldy[i] * vx_reg[i];
                vvx_reg[i] <= vx_reg[i] * vx_reg[i];
                vvy_reg[i] <= vy_reg[i] * vy_reg[i];
                wwx_reg[i] <= wx_reg[i] * wx_reg[i];
                wwy_reg[i] <= wy_reg[i] * wy_reg[i];
            end
            axx_reg  <= adx_reg * adx_reg;
            ayy_reg  <= ady_reg * ady_reg;
            bxx_reg  <= bdx_reg * bdx_reg;
            byy_reg  <= bdy_reg * bdy_reg;
            // UW is exactly 2*RW, so the full product fits
            rsq2_reg <= rsum_reg * rsum_reg;
            az2_reg  <= az1_reg;
            bz2_reg  <= bz1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f3_rdy)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                h_reg[i]  <= SW'(hx_reg[i]) + SW'(hy_reg[i]);
                cr_reg[i] <= SW'(c1_reg[i]) - SW'(c2_reg[i]);
                dv_reg[i] <= UW'($unsigned(vvx_reg[i])) + UW'($unsigned(vvy_reg[i]));
                dw_reg[i] <= UW'($unsigned(wwx_reg[i])) + UW'($unsigned(wwy_reg[i]));
            end
            la_reg   <= UW'($unsigned(axx_reg)) + UW'($unsigned(ayy_reg));
            lb_reg   <= UW'($unsigned(bxx_reg)) + UW'($unsigned(byy_reg));
            rsq3_reg <= rsq2_reg;
            az3_reg  <= az2_reg;
            bz3_reg  <= bz2_reg;
        end
    end

    // classification into a queue entry
    logic [LANES-1:0] cpos, cneg;
    logic [UW-1:0]    len;
    logic             hpos, hlt;
    logic signed [SW-1:0] ncr;

    always_comb
    begin
        push_data        = '0;
        push_data.a_zero = az3_reg;
        push_data.b_zero = bz3_reg;
        push_data.rsq    = rsq3_reg;
        len  = '0;
        hpos = 1'b0;
        hlt  = 1'b0;
        ncr  = '0;
        for (int i = 0; i < LANES; i++)
        begin
            len  = (i < 2) ? la_reg : lb_reg;
            hpos = !h_reg[i][SW-1] && (h_reg[i] != '0);
            hlt  = h_reg[i] < $signed({1'b0, len});
            ncr  = -cr_reg[i];
            cneg[i] = cr_reg[i][SW-1];
            cpos[i] = !cr_reg[i][SW-1] && (cr_reg[i] != '0);
            push_data.lane[i].len2   = len;
            push_data.lane[i].cr_abs = cr_reg[i][SW-1] ? ncr[UW-1:0] : cr_reg[i][UW-1:0];
            if (hpos && hlt)
            begin
                push_data.lane[i].mode  = MODE_SIDE;
                push_data.lane[i].dist2 = dv_reg[i];
            end
            else if (!hpos)
            begin
                push_data.lane[i].mode  = MODE_START;
                push_data.lane[i].dist2 = dv_reg[i];
            end
            else
            begin
                push_data.lane[i].mode  = MODE_END;
                push_data.lane[i].dist2 = dw_reg[i];
            end
        end
        // same strict sign on both ends of either segment means no crossing
        push_data.cross_hit = !((cpos[0] && cpos[1]) || (cneg[0] && cneg[1]))
                           && !((cpos[2] && cpos[3]) || (cneg[2] && cneg[3]));
    end

endmodule

`default_nettype wire

FILE: rtl/cot_queue.sv
//------------------------------------------------------------------------------
// cot_queue
// Short register queue between the classifying front and the back end.
//------------------------------------------------------------------------------
`default_nettype none

module cot_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire cot_pkg::entry_t push_data,
    input  wire logic            pop,
    output cot_pkg::entry_t      pop_data,
    output cot_pkg::q_stat_t     stat
);
    import cot_pkg::*;

    entry_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
        stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
        stat.empty = (count_reg == '0);
        pop_data   = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

FILE: rtl/cot_back.sv
//------------------------------------------------------------------------------
// cot_back
// Split squared compares per endpoint, then result selection and output register.
//------------------------------------------------------------------------------
`default_nettype none

module cot_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cot_pkg::q_stat_t stat,
    input  wire cot_pkg::entry_t  pop_data,
    output logic                  pop,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output cot_pkg::result_t      result
);
    import cot_pkg::*;

    logic b1_v_reg, b2_v_reg;
    logic b1_rdy, b2_rdy;

    mode_t           mode_reg [LANES];
    logic [2*HW-1:0] p_hh_reg [LANES];
    logic [2*HW-1:0] p_hl_reg [LANES];
    logic [2*HW-1:0] p_ll_reg [LANES];
    logic [2*HW-1:0] r_hh_reg [LANES];
    logic [2*HW-1:0] r_hl_reg [LANES];
    logic [2*HW-1:0] r_lh_reg [LANES];
    logic [2*HW-1:0] r_ll_reg [LANES];
    logic            disc_reg [LANES];
    logic            az_reg, bz_reg, cross_reg;
    result_t         result_reg;

    always_comb
    begin
        b2_rdy = !b2_v_reg || !result_stall;
        b1_rdy = !b1_v_reg || b2_rdy;
        pop    = !stat.empty && b1_rdy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
        end
        else
        begin
            if (b1_rdy)
                b1_v_reg <= !stat.empty;
            if (b2_rdy)
                b2_v_reg <= b1_v_reg;
        end
    end

    // cross^2 and rsum^2*len^2 as half-word partial products
    always_ff @(posedge clk)
    begin
        if (b1_rdy)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                mode_reg[i] <= pop_data.lane[i].mode;
                p_hh_reg[i] <= pop_data.lane[i].cr_abs[UW-1:HW] * pop_data.lane[i].cr_abs[UW-1:HW];
                p_hl_reg[i] <= pop_data.lane[i].cr_abs[UW-1:HW] * pop_data.lane[i].cr_abs[HW-1:0];
                p_ll_reg[i] <= pop_data.lane[i].cr_abs[HW-1:0] * pop_data.lane[i].cr_abs[HW-1:0];
                r_hh_reg[i] <= pop_data.rsq[UW-1:HW] * pop_data.lane[i].len2[UW-1:HW];
                r_hl_reg[i] <= pop_data.rsq[UW-1:HW] * pop_data.lane[i].len2[HW-1:0];
                r_lh_reg[i] <= pop_data.rsq[HW-1:0] * pop_data.lane[i].len2[UW-1:HW];
                r_ll_reg[i] <= pop_data.rsq[HW-1:0] * pop_data.lane[i].len2[HW-1:0];
                disc_reg[i] <= pop_data.lane[i].dist2 <= pop_data.rsq;
            end
            az_reg    <= pop_data.a_zero;
            bz_reg    <= pop_data.b_zero;
            cross_reg <= pop_data.cross_hit;
        end
    end

    logic [QW-1:0]    crsq, rlsq;
    logic [LANES-1:0] hit;
    result_t          result_next;

    always_comb
    begin
        crsq = '0;
        rlsq = '0;
        for (int i = 0; i < LANES; i++)
        begin
            crsq = (QW'(p_hh_reg[i]) << (2 * HW)) + (QW'(p_hl_reg[i]) << (HW + 1))
                 + QW'(p_ll_reg[i]);
            rlsq = (QW'(r_hh_reg[i]) << (2 * HW))
                 + ((QW'(r_hl_reg[i]) + QW'(r_lh_reg[i])) << HW) + QW'(r_ll_reg[i]);
            hit[i] = (mode_reg[i] == MODE_SIDE) ? (crsq <= rlsq) : disc_reg[i];
        end
        if (az_reg)
            result_next.contact_kind = hit[2] ? KIND_RADIUS : KIND_NONE;
        else if (bz_reg)
            result_next.contact_kind = hit[0] ? KIND_RADIUS : KIND_NONE;
        else if (cross_reg)
            result_next.contact_kind = KIND_CROSS;
        else if (hit != '0)
            result_next.contact_kind = KIND_RADIUS;
        else
            result_next.contact_kind = KIND_NONE;
        result_next.touching = (result_next.contact_kind != KIND_NONE);
    end

    always_ff @(posedge clk)
    begin
        if (b2_rdy)
            result_reg <= result_next;
    end

    assign result_valid = b2_v_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
